// ----- src/erm_pkg.sv -----
// shared types and constants of the euler rotation matrix block
package erm_pkg;

	// width of one angle field on the input stream
	localparam int ANGLE_W = 18;

	// q30 unit value and its rounding half
	localparam logic [30:0] Q_ONE = 31'h4000_0000;
	localparam logic [62:0] Q_HALF = 63'h2000_0000;

	// series steps per sine and cosine
	localparam int NCELL = 6;

	// horner divisors, innermost step first, with floor(2^33 / d)
	localparam logic [7:0] SIN_DIV [NCELL] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [NCELL] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
	localparam logic [30:0] SIN_RECIP [NCELL] = '{
		31'd55063683, 31'd78090314, 31'd119304647,
		31'd204522252, 31'd429496729, 31'd1431655765
	};
	localparam logic [30:0] COS_RECIP [NCELL] = '{
		31'd47197442, 31'd65075262, 31'd95443717,
		31'd153391689, 31'd286331153, 31'd715827882
	};

	// pipeline depths of each part
	localparam int PREP_LAT = 6;
	localparam int CELL_LAT = 3;
	localparam int FIN_LAT = 3;
	localparam int MAT_LAT = 3;
	localparam int PIPE_LAT = PREP_LAT + NCELL * CELL_LAT + FIN_LAT + MAT_LAT;

	// values that ride along the series chain
	typedef struct packed {
		logic [1:0] quad;
		logic [30:0] t;
	} sc_side_t;

	// signed q30 sine and cosine of one angle
	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] c;
	} sc_pair_t;

endpackage

// ----- src/erm_angle_prep.sv -----
// angle reduction, quadrant split, conversion to radians and squaring
module erm_angle_prep #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [17:0]            angle,
	output logic [31:0]            t2,
	output erm_pkg::sc_side_t      side
);

	localparam int FULL = 360 << ANGLE_FRAC_BITS;
	localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
	localparam int HALF_RANGE = 1 << (erm_pkg::ANGLE_W - 1);
	localparam int OFFS = FULL - (HALF_RANGE % FULL);
	localparam int YW = $clog2((1 << erm_pkg::ANGLE_W) + 2 * FULL);
	localparam int MR = (1 << YW) / FULL;
	localparam int MRW = $clog2(MR + 1);
	localparam int AW = $clog2(FULL);
	localparam int RW = $clog2(QUARTER);
	localparam int PW = RW + 35;
	localparam int PW1 = PW + 1;
	localparam int TSH = 10 + ANGLE_FRAC_BITS;
	localparam logic [34:0] DEG2RAD = 35'd19190098069;
	localparam logic [PW:0] TRND = PW1'(1) << (9 + ANGLE_FRAC_BITS);

	logic [YW-1:0]     y;
	logic [YW-1:0]     y_s1;
	logic [YW+MRW-1:0] yp_s1;
	logic [YW-1:0]     q0;
	logic [YW-1:0]     rem;
	logic [YW-1:0]     a;
	logic [AW-1:0]     a_s2;
	logic [1:0]        quad;
	logic [AW-1:0]     r;
	logic [1:0]        quad_s3;
	logic [RW-1:0]     r_s3;
	logic [1:0]        quad_s4;
	logic [PW-1:0]     rk_s4;
	logic [PW:0]       rk_sum;
	logic [1:0]        quad_s5;
	logic [30:0]       t_s5;
	logic [61:0]       tt;
	logic [31:0]       t2_s6;
	erm_pkg::sc_side_t side_s6;

	// shift the signed angle to an unsigned value congruent modulo a full turn
	assign y = YW'({~angle[17], angle[16:0]}) + YW'(OFFS);

	// quotient estimate is at most one short, one compare fixes it
	assign q0 = YW'(yp_s1 >> YW);
	assign rem = y_s1 - q0 * YW'(FULL);
	assign a = (rem >= YW'(FULL)) ? rem - YW'(FULL) : rem;

	always_comb begin
		if (a_s2 >= AW'(3 * QUARTER)) begin
			quad = 2'd3;
			r = a_s2 - AW'(3 * QUARTER);
		end else if (a_s2 >= AW'(2 * QUARTER)) begin
			quad = 2'd2;
			r = a_s2 - AW'(2 * QUARTER);
		end else if (a_s2 >= AW'(QUARTER)) begin
			quad = 2'd1;
			r = a_s2 - AW'(QUARTER);
		end else begin
			quad = 2'd0;
			r = a_s2;
		end
	end

	assign rk_sum = PW1'(rk_s4) + TRND;
	assign tt = 62'(t_s5) * 62'(t_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= y;
			yp_s1 <= (YW + MRW)'(y) * (YW + MRW)'(MR);
			a_s2 <= AW'(a);
			quad_s3 <= quad;
			r_s3 <= RW'(r);
			quad_s4 <= quad_s3;
			rk_s4 <= PW'(r_s3) * PW'(DEG2RAD);
			quad_s5 <= quad_s4;
			t_s5 <= 31'(rk_sum >> TSH);
			t2_s6 <= 32'((63'(tt) + erm_pkg::Q_HALF) >> 30);
			side_s6.quad <= quad_s5;
			side_s6.t <= t_s5;
		end
	end

	assign t2 = t2_s6;
	assign side = side_s6;

endmodule

// ----- src/erm_horner_cell.sv -----
// one horner step of the sine and cosine series, three register stages
module erm_horner_cell #(
	parameter logic [7:0]  S_DIV = 8'd6,
	parameter logic [30:0] S_RECIP = 31'd1431655765,
	parameter logic [7:0]  C_DIV = 8'd12,
	parameter logic [30:0] C_RECIP = 31'd715827882
) (
	input  logic              clk,
	input  logic              en,
	input  logic [31:0]       t2_i,
	input  logic [30:0]       ps_i,
	input  logic [30:0]       pc_i,
	input  erm_pkg::sc_side_t side_i,
	output logic [31:0]       t2_o,
	output logic [30:0]       ps_o,
	output logic [30:0]       pc_o,
	output erm_pkg::sc_side_t side_o
);

	localparam logic [7:0]  DIV [2] = '{S_DIV, C_DIV};
	localparam logic [30:0] RECIP [2] = '{S_RECIP, C_RECIP};

	logic [30:0]       p_in [2];
	logic [62:0]       m_s1 [2];
	logic [32:0]       y [2];
	logic [32:0]       y_s2 [2];
	logic [63:0]       yp_s2 [2];
	logic [31:0]       q0 [2];
	logic [32:0]       rem [2];
	logic [31:0]       q [2];
	logic [30:0]       p_s3 [2];
	logic [31:0]       t2_s1, t2_s2, t2_s3;
	erm_pkg::sc_side_t side_s1, side_s2, side_s3;

	assign p_in[0] = ps_i;
	assign p_in[1] = pc_i;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			y[l] = 33'((m_s1[l] + erm_pkg::Q_HALF) >> 30) + 33'(DIV[l] >> 1);
			q0[l] = 32'(yp_s2[l] >> 33);
			rem[l] = y_s2[l] - 33'(q0[l]) * 33'(DIV[l]);
			q[l] = (rem[l] >= 33'(DIV[l])) ? q0[l] + 32'd1 : q0[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				m_s1[l] <= 63'(t2_i) * 63'(p_in[l]);
				y_s2[l] <= y[l];
				yp_s2[l] <= 64'(y[l]) * 64'(RECIP[l]);
				p_s3[l] <= erm_pkg::Q_ONE - 31'(q[l]);
			end
			t2_s1 <= t2_i;
			t2_s2 <= t2_s1;
			t2_s3 <= t2_s2;
			side_s1 <= side_i;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	assign t2_o = t2_s3;
	assign ps_o = p_s3[0];
	assign pc_o = p_s3[1];
	assign side_o = side_s3;

endmodule

// ----- src/erm_sincos.sv -----
// sine and cosine of one angle: preparation, chain of series cells, quadrant fold
module erm_sincos #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic              clk,
	input  logic              en,
	input  logic [17:0]       angle,
	output erm_pkg::sc_pair_t sc
);

	logic [31:0]       t2_c [erm_pkg::NCELL+1];
	logic [30:0]       ps_c [erm_pkg::NCELL+1];
	logic [30:0]       pc_c [erm_pkg::NCELL+1];
	erm_pkg::sc_side_t side_c [erm_pkg::NCELL+1];

	logic [61:0]       sp_s1;
	logic [62:0]       cv_s1;
	logic [1:0]        quad_s1, quad_s2;
	logic [31:0]       s_raw;
	logic [31:0]       x_raw;
	logic [31:0]       x_half;
	logic [30:0]       s_s2, c_s2;
	logic [30:0]       s_val, c_val;
	erm_pkg::sc_pair_t sc_s3;

	erm_angle_prep #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_prep (
		.clk  (clk),
		.en   (en),
		.angle(angle),
		.t2   (t2_c[0]),
		.side (side_c[0])
	);

	assign ps_c[0] = erm_pkg::Q_ONE;
	assign pc_c[0] = erm_pkg::Q_ONE;

	for (genvar g = 0; g < erm_pkg::NCELL; g++) begin : g_cell
		erm_horner_cell #(
			.S_DIV  (erm_pkg::SIN_DIV[g]),
			.S_RECIP(erm_pkg::SIN_RECIP[g]),
			.C_DIV  (erm_pkg::COS_DIV[g]),
			.C_RECIP(erm_pkg::COS_RECIP[g])
		) u_cell (
			.clk   (clk),
			.en    (en),
			.t2_i  (t2_c[g]),
			.ps_i  (ps_c[g]),
			.pc_i  (pc_c[g]),
			.side_i(side_c[g]),
			.t2_o  (t2_c[g+1]),
			.ps_o  (ps_c[g+1]),
			.pc_o  (pc_c[g+1]),
			.side_o(side_c[g+1])
		);
	end

	// sine clamps at one, cosine at zero
	assign s_raw = 32'((63'(sp_s1) + erm_pkg::Q_HALF) >> 30);
	assign x_raw = 32'((cv_s1 + erm_pkg::Q_HALF) >> 30);
	assign x_half = 32'((33'(x_raw) + 33'd1) >> 1);
	assign s_val = (s_raw > 32'(erm_pkg::Q_ONE)) ? erm_pkg::Q_ONE : 31'(s_raw);
	assign c_val = (x_half >= 32'(erm_pkg::Q_ONE)) ? 31'd0 : erm_pkg::Q_ONE - 31'(x_half);

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1 <= 62'(side_c[erm_pkg::NCELL].t) * 62'(ps_c[erm_pkg::NCELL]);
			cv_s1 <= 63'(t2_c[erm_pkg::NCELL]) * 63'(pc_c[erm_pkg::NCELL]);
			quad_s1 <= side_c[erm_pkg::NCELL].quad;
			s_s2 <= s_val;
			c_s2 <= c_val;
			quad_s2 <= quad_s1;
			case (quad_s2)
				2'd0: begin
					sc_s3.s <= $signed({1'b0, s_s2});
					sc_s3.c <= $signed({1'b0, c_s2});
				end
				2'd1: begin
					sc_s3.s <= $signed({1'b0, c_s2});
					sc_s3.c <= -$signed({1'b0, s_s2});
				end
				2'd2: begin
					sc_s3.s <= -$signed({1'b0, s_s2});
					sc_s3.c <= -$signed({1'b0, c_s2});
				end
				default: begin
					sc_s3.s <= -$signed({1'b0, c_s2});
					sc_s3.c <= $signed({1'b0, s_s2});
				end
			endcase
		end
	end

	assign sc = sc_s3;

endmodule

// ----- src/erm_matrix.sv -----
// products and sums of the nine matrix entries, output rounding and saturation
module erm_matrix #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  erm_pkg::sc_pair_t          scx,
	input  erm_pkg::sc_pair_t          scy,
	input  erm_pkg::sc_pair_t          scz,
	output logic [OUT_FRAC_BITS+1:0]   r [9]
);

	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic [32:0] RND = 33'((64'd1 << SH) >> 1);
	localparam logic [32:0] LIM = 33'd1 << OUT_FRAC_BITS;

	// signed q30 product, magnitude rounded half up
	function automatic logic signed [31:0] smulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [31:0] ua, ub;
		logic [63:0] m;
		logic [31:0] mr;
		ua = a[31] ? 32'(-a) : 32'(a);
		ub = b[31] ? 32'(-b) : 32'(b);
		m = 64'(ua[30:0]) * 64'(ub[30:0]);
		mr = 32'((m + 64'(erm_pkg::Q_HALF)) >> 30);
		return (a[31] ^ b[31]) ? -$signed(mr) : $signed(mr);
	endfunction

	function automatic logic [OW-1:0] emit(input logic signed [32:0] e);
		logic [32:0] m;
		logic [32:0] mr;
		m = e[32] ? 33'(-e) : 33'(e);
		mr = 33'((34'(m) + 34'(RND)) >> SH);
		if (mr > LIM)
			mr = LIM;
		return e[32] ? OW'(-mr) : OW'(mr);
	endfunction

	logic signed [31:0] czsy_s1, szsy_s1;
	erm_pkg::sc_pair_t  x_s1, y_s1, z_s1;
	logic signed [31:0] czcy_s2, czsysx_s2, szcx_s2, czsycx_s2, szsx_s2, szcy_s2;
	logic signed [31:0] szsysx_s2, czcx_s2, szsycx_s2, czsx_s2, cysx_s2, cycx_s2;
	logic signed [31:0] sy_s2;
	logic signed [32:0] e_s3 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			czsy_s1 <= smulq(scz.c, scy.s);
			szsy_s1 <= smulq(scz.s, scy.s);
			x_s1 <= scx;
			y_s1 <= scy;
			z_s1 <= scz;

			czcy_s2 <= smulq(z_s1.c, y_s1.c);
			czsysx_s2 <= smulq(czsy_s1, x_s1.s);
			szcx_s2 <= smulq(z_s1.s, x_s1.c);
			czsycx_s2 <= smulq(czsy_s1, x_s1.c);
			szsx_s2 <= smulq(z_s1.s, x_s1.s);
			szcy_s2 <= smulq(z_s1.s, y_s1.c);
			szsysx_s2 <= smulq(szsy_s1, x_s1.s);
			czcx_s2 <= smulq(z_s1.c, x_s1.c);
			szsycx_s2 <= smulq(szsy_s1, x_s1.c);
			czsx_s2 <= smulq(z_s1.c, x_s1.s);
			cysx_s2 <= smulq(y_s1.c, x_s1.s);
			cycx_s2 <= smulq(y_s1.c, x_s1.c);
			sy_s2 <= y_s1.s;

			e_s3[0] <= 33'(czcy_s2);
			e_s3[1] <= -33'(czsysx_s2) - 33'(szcx_s2);
			e_s3[2] <= -33'(czsycx_s2) + 33'(szsx_s2);
			e_s3[3] <= 33'(szcy_s2);
			e_s3[4] <= -33'(szsysx_s2) + 33'(czcx_s2);
			e_s3[5] <= -33'(szsycx_s2) - 33'(czsx_s2);
			e_s3[6] <= 33'(sy_s2);
			e_s3[7] <= 33'(cysx_s2);
			e_s3[8] <= 33'(cycx_s2);
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++)
			r[k] = emit(e_s3[k]);
	end

endmodule

// ----- src/euler_rotation_matrix.sv -----
// top level of the zyx euler angle rotation matrix block
// Takes three angles in degrees (two's complement, ANGLE_FRAC_BITS fraction
// bits) and returns the nine entries of the 3x3 rotation Rz*Ry*Rx, each
// rounded to OUT_FRAC_BITS fraction bits and saturated to +-1.0. Ry carries
// -sin(y) at row 0, column 2 and +sin(y) at row 2, column 0. The block is a
// fully pipelined datapath: one angle triple can be taken every cycle while
// the pipeline is not frozen, and its matrix passes through 6 stages of angle
// reduction and conversion, a chain of 6 series cells of 3 stages each, 3
// stages of sine and cosine finishing, 3 stages of matrix products and sums,
// and the output register. Throughput is one transfer per cycle while not
// frozen; most of the depth lies in the six horner cells, each holding one
// multiply, one reciprocal multiply and one correction step. When the output
// is held by a stalled sink the pipeline freezes, except that a bubble just
// ahead of the output register is squeezed out.
module euler_rotation_matrix #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,   // angle_x, angle_y, angle_z, zero fill
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [((9 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] m_tdata
	// m_tdata: r00, r01, r02, r10, r11, r12, r20, r21, r22, zero fill
);

	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int DW = ((9 * OW + 7) / 8) * 8;
	localparam int LAT = erm_pkg::PIPE_LAT;

	erm_pkg::sc_pair_t sc [3];
	logic [OW-1:0]     r [9];
	logic [DW-1:0]     pack;
	logic [LAT-1:0]    vld_q;
	logic              m_tvalid_q;
	logic [DW-1:0]     m_tdata_q;
	logic              out_ld;
	logic              en;

	// output register is free or drains this cycle
	assign out_ld = !m_tvalid_q || m_tready;
	// pipeline moves if the result can land or the last stage holds a bubble
	assign en = out_ld || !vld_q[LAT-1];
	assign s_tready = en;

	// one sine and cosine pipe per angle
	for (genvar a = 0; a < 3; a++) begin : g_angle
		erm_sincos #(
			.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
		) u_sincos (
			.clk  (clk),
			.en   (en),
			.angle(s_tdata[a*erm_pkg::ANGLE_W +: erm_pkg::ANGLE_W]),
			.sc   (sc[a])
		);
	end

	erm_matrix #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_matrix (
		.clk(clk),
		.en (en),
		.scx(sc[0]),
		.scy(sc[1]),
		.scz(sc[2]),
		.r  (r)
	);

	// entries packed from the lowest bit up
	always_comb begin
		pack = '0;
		for (int k = 0; k < 9; k++)
			pack[k*OW +: OW] = r[k];
	end

	// valid bits follow the data through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (en)
				vld_q <= {vld_q[LAT-2:0], s_tvalid};
			if (out_ld)
				m_tvalid_q <= vld_q[LAT-1];
		end
	end

	// output payload, loaded only when a result lands
	always_ff @(posedge clk) begin
		if (out_ld && vld_q[LAT-1])
			m_tdata_q <= pack;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
